// File: rtl/xcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, protocol characters and the bytewise CRC-16 update for the
// XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xcrc_pkg;

  // Field widths fixed by the interface.
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 2;
  localparam int KIND_W = 2;
  localparam int POS_W  = 20;
  localparam int CRC_W  = 16;

  // Request codes carried on the input side tuser.
  localparam logic [REQ_W-1:0] REQ_BYTE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START   = 2'd2;

  // Protocol characters.
  localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] CH_CAN = 8'h18;
  localparam logic [BYTE_W-1:0] CH_C   = 8'h43;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Depth of the result queue; it must hold two results beyond a stalled one.
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_STOPPED  = 3'd0,
    PH_HEADER   = 3'd1,
    PH_BLOCK    = 3'd2,
    PH_BLOCKINV = 3'd3,
    PH_DATA     = 3'd4,
    PH_CRCHI    = 3'd5,
    PH_CRCLO    = 3'd6
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_PAYLOAD = 2'd0,
    K_SEND    = 2'd1,
    K_DONE    = 2'd2,
    K_FAIL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              last;
  } res_t;

  // Results produced by one item: count (0 to 2) and the two slots.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } core_out_t;

  // CRC-16/XMODEM update over one byte, MSB first.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/xcrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_core
// Protocol state and per-item decision logic: block checks, CRC, byte count.
// ----------------------------------------------------------------------------
module xcrc_core import xcrc_pkg::*; #(
  parameter int PACKET_BYTES = 128,
  parameter int COUNT_BITS   = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [BYTE_W-1:0] rx_byte,
  output core_out_t         res
);

  localparam int IDX_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PACKET_BYTES - 1);

  phase_t                phase, phase_next;
  logic                  still_starting, still_starting_next;
  logic [BYTE_W-1:0]     expected_block, expected_block_next;
  logic [IDX_W-1:0]      data_index, data_index_next;
  logic [CRC_W-1:0]      running_crc, running_crc_next;
  logic [COUNT_BITS-1:0] received_count, received_count_next;

  logic [CRC_W-1:0]      crc_upd;
  logic                  is_byte;
  logic                  is_timeout;
  logic                  fail_now;

  assign crc_upd    = crc_byte(running_crc, rx_byte);
  assign is_byte    = (req_type == REQ_BYTE);
  assign is_timeout = (req_type == REQ_TIMEOUT);

  always_comb begin
    phase_next          = phase;
    still_starting_next = still_starting;
    expected_block_next = expected_block;
    data_index_next     = data_index;
    running_crc_next    = running_crc;
    received_count_next = received_count;
    fail_now            = 1'b0;
    res                 = '0;
    res.r0.kind         = K_SEND;
    res.r1.kind         = K_SEND;

    if (take) begin
      if (req_type == REQ_START) begin
        phase_next          = PH_HEADER;
        still_starting_next = 1'b1;
        expected_block_next = 8'd1;
        data_index_next     = '0;
        running_crc_next    = '0;
        received_count_next = '0;
        res.num             = 2'd1;
        res.r0.value        = CH_C;
        res.r0.last         = 1'b1;
      end else if (is_byte || is_timeout) begin
        case (phase)
          PH_STOPPED: begin
          end
          PH_HEADER: begin
            if (is_byte && rx_byte == CH_EOT) begin
              phase_next       = PH_STOPPED;
              res.num          = 2'd2;
              res.r0.value     = CH_ACK;
              res.r1.kind      = K_DONE;
              res.r1.position  = POS_W'(received_count);
              res.r1.last      = 1'b1;
            end else if (is_byte && rx_byte == CH_SOH) begin
              still_starting_next = 1'b0;
              data_index_next     = '0;
              running_crc_next    = '0;
              phase_next          = PH_BLOCK;
            end else if (still_starting) begin
              res.num      = 2'd1;
              res.r0.value = CH_C;
              res.r0.last  = 1'b1;
            end
          end
          PH_BLOCK: begin
            if (is_timeout || rx_byte != expected_block) begin
              fail_now = 1'b1;
            end else begin
              phase_next = PH_BLOCKINV;
            end
          end
          PH_BLOCKINV: begin
            if (is_timeout || rx_byte != ~expected_block) begin
              fail_now = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (is_timeout || (&received_count)) begin
              fail_now = 1'b1;
            end else begin
              running_crc_next    = crc_upd;
              res.num             = 2'd1;
              res.r0.kind         = K_PAYLOAD;
              res.r0.value        = rx_byte;
              res.r0.position     = POS_W'(received_count);
              res.r0.last         = 1'b1;
              received_count_next = received_count + COUNT_BITS'(1);
              if (data_index == IDX_LAST) begin
                data_index_next = '0;
                phase_next      = PH_CRCHI;
              end else begin
                data_index_next = data_index + IDX_W'(1);
              end
            end
          end
          PH_CRCHI: begin
            if (is_timeout || rx_byte != running_crc[15:8]) begin
              fail_now = 1'b1;
            end else begin
              phase_next = PH_CRCLO;
            end
          end
          PH_CRCLO: begin
            if (is_timeout || rx_byte != running_crc[7:0]) begin
              fail_now = 1'b1;
            end else begin
              expected_block_next = expected_block + 8'd1;
              data_index_next     = '0;
              running_crc_next    = '0;
              phase_next          = PH_HEADER;
              res.num             = 2'd1;
              res.r0.value        = CH_ACK;
              res.r0.last         = 1'b1;
            end
          end
          default: begin
            phase_next = PH_STOPPED;
          end
        endcase

        // Any error inside a block: cancel the transfer and report failure.
        if (fail_now) begin
          phase_next   = PH_STOPPED;
          res.num      = 2'd2;
          res.r0.kind  = K_SEND;
          res.r0.value = CH_CAN;
          res.r0.last  = 1'b0;
          res.r1.kind  = K_FAIL;
          res.r1.last  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_STOPPED;
      still_starting <= 1'b1;
      expected_block <= 8'd1;
      data_index     <= '0;
      running_crc    <= '0;
      received_count <= '0;
    end else begin
      phase          <= phase_next;
      still_starting <= still_starting_next;
      expected_block <= expected_block_next;
      data_index     <= data_index_next;
      running_crc    <= running_crc_next;
      received_count <= received_count_next;
    end
  end

  // Two results always mean a transmit followed by the closing result.
  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    res.num == 2'd2 |-> res.r0.kind == K_SEND && !res.r0.last && res.r1.last)
    else $error("two-result item has the wrong shape");

  // A done or failure result always leaves the transfer stopped.
  a_stop_after_pair: assert property (@(posedge clk) disable iff (rst)
    res.num == 2'd2 |=> phase == PH_STOPPED)
    else $error("transfer not stopped after done or failure");

  // While stopped, only a start produces anything.
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_STOPPED && req_type != REQ_START |-> res.num == 2'd0)
    else $error("result produced while stopped");

endmodule

// File: rtl/xcrc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcrc_out_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module xcrc_out_fifo import xcrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_out_t push,
  output logic      room2,
  output logic      out_valid,
  output res_t      out_res,
  input  logic      out_ready
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign wr_ptr1   = wr_ptr + PTR_W'(1);
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.num) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.num != 2'd0 |-> room2)
    else $error("push into a queue without room for two results");

endmodule

// File: rtl/xmodem_crc_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_crc_receiver
// Receiver side of XMODEM-CRC with bytewise CRC-16 checking and abort on error.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result queue
// (four entries) before it shows on the master side.
// Throughput: one input per cycle while the queue has room for two results;
// an item yields up to two, drained one per cycle while m_tready is high.
// Reset (rst, synchronous): the transfer is stopped, counters and CRC cleared,
// expected block number one, and both the input register and queue emptied.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver import xcrc_pkg::*; #(
  parameter int PACKET_BYTES = 128,
  parameter int COUNT_BITS   = 20
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] value, [27:8] position, [31:28] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last result caused by one input item
);

  // Input register. It is refilled in the same cycle its item moves into
  // the core, so a back-to-back stream flows at one item per clock as long
  // as the result queue has room for the worst case of two results.
  logic              in_valid;
  logic [REQ_W-1:0]  in_req;
  logic [BYTE_W-1:0] in_byte;
  logic              room2;
  logic              take;
  core_out_t         core_res;
  res_t              out_res;

  assign take     = in_valid && room2;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload needs no reset; it is only looked at while in_valid is set.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // Protocol state machine, block checks and CRC.
  xcrc_core #(
    .PACKET_BYTES(PACKET_BYTES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .req_type(in_req),
    .rx_byte (in_byte),
    .res     (core_res)
  );

  // Result queue that also serves as the output register.
  xcrc_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (core_res),
    .room2    (room2),
    .out_valid(m_tvalid),
    .out_res  (out_res),
    .out_ready(m_tready)
  );

  assign m_tdata = {4'b0000, out_res.position, out_res.value};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  // An item held back by a full queue stays in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !room2 |=> in_valid)
    else $error("input item lost while the queue was full");

endmodule
